/* hdl/scfdr_pkg.sv */
// scfdr_pkg: types and constants shared by the serial frame deframer files
// no dependencies
`timescale 1ns / 1ps

package scfdr_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  // payload bytes kept per frame; longer frames are read through and rejected
  localparam logic [7:0] PAYLOAD_CAPACITY = 8'd250;

  // command type class, top three bits of the type byte
  localparam logic [7:0] CLASS_MASK     = 8'hE0;
  localparam logic [7:0] CLASS_RESPONSE = 8'h60;
  localparam logic [7:0] CLASS_ASYNC    = 8'h40;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_ID    = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_GOOD      = 2'd1,
    KIND_CHECK_ERR = 2'd2,
    KIND_OVERSIZE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ROUTE_MATCHED   = 2'd0,
    ROUTE_UNMATCHED = 2'd1,
    ROUTE_ASYNC     = 2'd2,
    ROUTE_UNKNOWN   = 2'd3
  } route_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE   = 8'd0,
    REG_PENDING_TYPE = 8'd1,
    REG_PENDING_ID   = 8'd2,
    REG_RESET_IND_ID = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type_byte;
    logic [7:0]  frame_length;
    logic [1:0]  route;
    logic        reset_indication;
    logic [15:0] errors_seen;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           value;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] pending_type;
    logic [7:0] pending_id;
    logic [7:0] reset_ind_id;
  } cfg_regs_t;

endpackage

/* hdl/scfdr_chan_if.sv */
// scfdr_chan_if: valid/ready channel carrying one payload item per transfer
// payload type is given per instance, normally a struct from scfdr_pkg
`timescale 1ns / 1ps

interface scfdr_chan_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/scfdr_parser.sv */
// scfdr_parser: frame parser state machine, check accumulation and routing
// depends on scfdr_pkg
`timescale 1ns / 1ps

module scfdr_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  scfdr_pkg::cfg_regs_t  cfg,
  output logic                  res_valid,
  output scfdr_pkg::out_item_t  res
);

  scfdr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  check_r, check_nxt;
  logic [15:0] tally_r, tally_nxt;
  logic [7:0]  count_inc;
  logic [7:0]  cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scfdr_pkg::PH_HUNT;
      len_r   <= '0;
      type_r  <= '0;
      id_r    <= '0;
      count_r <= '0;
      check_r <= '0;
      tally_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      id_r    <= id_nxt;
      count_r <= count_nxt;
      check_r <= check_nxt;
      tally_r <= tally_nxt;
    end
  end

  assign count_inc = count_r + 8'd1;
  assign cls       = type_r & scfdr_pkg::CLASS_MASK;

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    id_nxt    = id_r;
    count_nxt = count_r;
    check_nxt = check_r;
    tally_nxt = tally_r;
    res_valid = 1'b0;
    res.result_kind      = scfdr_pkg::KIND_DATA;
    res.data_byte        = id_r;
    res.frame_type_byte  = type_r;
    res.frame_length     = len_r;
    res.route            = scfdr_pkg::ROUTE_MATCHED;
    res.reset_indication = 1'b0;
    res.errors_seen      = tally_r;
    unique case (phase_r)
      scfdr_pkg::PH_LEN: begin
        len_nxt   = rx_byte;
        check_nxt = rx_byte;
        phase_nxt = scfdr_pkg::PH_TYPE;
      end
      scfdr_pkg::PH_TYPE: begin
        type_nxt  = rx_byte;
        check_nxt = check_r ^ rx_byte;
        phase_nxt = scfdr_pkg::PH_ID;
      end
      scfdr_pkg::PH_ID: begin
        id_nxt    = rx_byte;
        check_nxt = check_r ^ rx_byte;
        count_nxt = '0;
        phase_nxt = (len_r != 8'd0) ? scfdr_pkg::PH_DATA : scfdr_pkg::PH_CHECK;
      end
      scfdr_pkg::PH_DATA: begin
        check_nxt = check_r ^ rx_byte;
        count_nxt = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = scfdr_pkg::PH_CHECK;
        end
        // bytes past the capacity are folded into the check but not forwarded
        if (count_r < scfdr_pkg::PAYLOAD_CAPACITY) begin
          res_valid     = 1'b1;
          res.data_byte = rx_byte;
        end
      end
      scfdr_pkg::PH_CHECK: begin
        phase_nxt = scfdr_pkg::PH_HUNT;
        res_valid = 1'b1;
        if (len_r > scfdr_pkg::PAYLOAD_CAPACITY || rx_byte != check_r) begin
          if (tally_r != 16'hFFFF) begin
            tally_nxt = tally_r + 16'd1;
          end
          res.result_kind = (len_r > scfdr_pkg::PAYLOAD_CAPACITY) ?
                            scfdr_pkg::KIND_OVERSIZE : scfdr_pkg::KIND_CHECK_ERR;
        end else begin
          res.result_kind = scfdr_pkg::KIND_GOOD;
          if (cls == scfdr_pkg::CLASS_RESPONSE) begin
            res.route = (type_r == cfg.pending_type && id_r == cfg.pending_id) ?
                        scfdr_pkg::ROUTE_MATCHED : scfdr_pkg::ROUTE_UNMATCHED;
          end else if (cls == scfdr_pkg::CLASS_ASYNC) begin
            res.route            = scfdr_pkg::ROUTE_ASYNC;
            res.reset_indication = (id_r == cfg.reset_ind_id);
          end else begin
            res.route = scfdr_pkg::ROUTE_UNKNOWN;
          end
        end
        res.errors_seen = tally_nxt;
      end
      default: begin
        // hunting, and any unused phase code
        phase_nxt = (rx_byte == cfg.start_byte) ? scfdr_pkg::PH_LEN : scfdr_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

/* hdl/serial_command_frame_deframer_router.sv */
// serial_command_frame_deframer_router: top level, byte input register,
// result register and configuration registers; depends on scfdr_pkg,
// scfdr_chan_if and scfdr_parser
`timescale 1ns / 1ps

// Deframes received serial bytes: waits for the start byte, then reads length,
// command type, command id, payload and an xor check byte. Every payload byte
// (up to the capacity of 250) comes out as a transfer of kind payload; the check
// byte yields one verdict transfer (good frame with its route, check error, or
// oversize) that also carries the saturating count of rejected frames. Frames
// declaring more than 250 payload bytes are read to their end and rejected.
// Rate: one byte per clock sustained while the output is not stalled. Each byte
// is registered in the input register at its transfer; the parser state machine
// then handles it once the result register is free and writes any result it
// produces there, from where the result is offered on the output. The
// input only stalls while the result register is full and not being taken.
// Configuration writes are never stalled and are meant for idle periods.

module serial_command_frame_deframer_router (
  input  logic         clk,
  input  logic         rst_n,
  scfdr_chan_if.sink   in_chan,
  scfdr_chan_if.source out_chan,
  scfdr_chan_if.sink   cfg_chan
);

  // configuration registers
  scfdr_pkg::cfg_regs_t cfg_r;

  // input stage
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  // result stage
  logic                 out_valid_r, out_valid_nxt;
  scfdr_pkg::out_item_t out_data_r;

  // parser hookup
  logic                 step;
  logic                 res_valid;
  scfdr_pkg::out_item_t res;
  logic                 out_free;
  logic                 in_xfer;

  // config write port never stalls
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte   <= 8'hFE;
      cfg_r.pending_type <= 8'h00;
      cfg_r.pending_id   <= 8'h00;
      cfg_r.reset_ind_id <= 8'h80;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.index)
        scfdr_pkg::REG_START_BYTE:   cfg_r.start_byte   <= cfg_chan.data.value;
        scfdr_pkg::REG_PENDING_TYPE: cfg_r.pending_type <= cfg_chan.data.value;
        scfdr_pkg::REG_PENDING_ID:   cfg_r.pending_id   <= cfg_chan.data.value;
        scfdr_pkg::REG_RESET_IND_ID: cfg_r.reset_ind_id <= cfg_chan.data.value;
        default: begin
          // indexes past the register list are dropped
        end
      endcase
    end
  end

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_chan.ready;
  // the held byte moves through the parser whenever its result has somewhere to go
  assign step     = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || out_free;
  assign in_xfer  = in_chan.valid && in_chan.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_chan.data.rx_byte;
    end
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

  scfdr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

/* hdl/scfdr_checker.sv */
// scfdr_checker: port-level assertions for the deframer result channel
// depends on scfdr_pkg; bound to serial_command_frame_deframer_router below
`timescale 1ns / 1ps

module scfdr_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input scfdr_pkg::out_item_t out_data
);

  logic [15:0] last_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
    end else if (out_valid && out_ready) begin
      last_err_r <= out_data.errors_seen;
    end
  end

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // the rejected frame count never goes backward between transfers
  a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.errors_seen >= last_err_r)
    else $error("error count decreased");

  // only a good asynchronous frame can flag a reset indication
  a_reset_ind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reset_indication |->
      out_data.result_kind == scfdr_pkg::KIND_GOOD &&
      out_data.route == scfdr_pkg::ROUTE_ASYNC)
    else $error("reset indication on a non-async result");

  // payload and rejected results carry the default route
  a_route_default: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != scfdr_pkg::KIND_GOOD |->
      out_data.route == scfdr_pkg::ROUTE_MATCHED)
    else $error("route set on a non-good result");

endmodule

bind serial_command_frame_deframer_router scfdr_checker u_scfdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);
